// ===== rtl/bia_pkg.sv =====
// Shared types and codes for the bitmap ID allocator.
// Holds the request and response word structs and the status codes.
// No dependencies.
package bia_pkg;

   localparam int ID_W        = 10;
   localparam int STATUS_W    = 2;
   localparam int RECIP_SHIFT = 24;

   localparam logic REQ_ALLOCATE = 1'b0;
   localparam logic REQ_RELEASE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RELEASED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_FREE   = 2'd2;

   typedef struct packed {
      logic            req_type;
      logic [ID_W-1:0] release_id;
   } req_word_type;

   typedef struct packed {
      logic [ID_W-1:0]     granted_id;
      logic [STATUS_W-1:0] status;
   } rsp_word_type;

endpackage

// ===== rtl/bia_map_ram.sv =====
// Simple dual-port RAM holding the used-ID bitmap, one word per row.
// One write port and one read port with registered read data.
// No dependencies.
module bia_map_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bitmap_id_allocator_top.sv =====
// Bitmap ID allocator: lowest-free ID allocation and release over a RAM bitmap.
// Depends on bia_pkg and bia_map_ram.
//
// Usage:
//   The request channel (req_valid / req_stall / req_word) takes one word per
//   allocate or release. The response channel (rsp_valid / rsp_stall /
//   rsp_word) returns exactly one word per request, in request order.
//   An allocate reads the first non-full bitmap row, named by a per-row full
//   flag, sets its lowest clear bit and writes the row back. A release reads
//   the named row, clears the bit and writes it back.
//   A request that touches the bitmap RAM answers after the RAM read and then the
//   modify/write state; a full-bitmap allocate or a release beyond capacity
//   answers in the next cycle. A RAM request stalls the channel during its modify
//   state, so the next request waits; others go back to back unless rsp_stall holds.
//   Reset clears the full flags and a fill count of rows ever written; rows at
//   or above the fill count read as zero, so no clearing pass is needed and
//   the block accepts requests in the first cycle after reset.
//   While the receiver stalls a pending response, req_stall stays high and
//   the response word holds.
module bitmap_id_allocator_top
   import bia_pkg::*;
#(
   parameter int NUM_WORDS = 32,
   parameter int WORD_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   localparam int AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int HW = $clog2(NUM_WORDS + 1);
   localparam int BW = $clog2(WORD_BITS);
   localparam logic [23:0] RECIP = 24'((2**RECIP_SHIFT + WORD_BITS - 1) / WORD_BITS);

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   state_type             state_ff;
   logic                  op_ff;
   logic [ID_W-1:0]       id_ff;
   logic [AW-1:0]         word_ff;
   logic [NUM_WORDS-1:0]  full_ff;
   logic [HW-1:0]         hwm_ff;
   logic                  rsp_valid_ff;
   rsp_word_type          rsp_word_ff;

   logic                  accept;
   logic                  rsp_take;
   logic                  rsp_done;
   logic [NUM_WORDS-1:0]  full_p1;
   logic [NUM_WORDS-1:0]  free_oh;
   logic                  any_free;
   logic [AW-1:0]         free_word;
   logic [33:0]           rel_prod;
   logic [ID_W-1:0]       rel_word;
   logic                  rel_in_range;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [WORD_BITS-1:0]  rd_data;

   logic [WORD_BITS-1:0]  cur_word;
   logic [WORD_BITS-1:0]  cur_p1;
   logic [WORD_BITS-1:0]  zero_oh;
   logic [BW-1:0]         zero_bit;
   logic [WORD_BITS-1:0]  set_word;
   logic [31:0]           row_base;
   logic [31:0]           grant_sum;
   logic [ID_W-1:0]       rel_off;
   logic [BW-1:0]         rel_bit;
   logic [WORD_BITS-1:0]  clr_word;
   logic                  wr_en;
   logic [WORD_BITS-1:0]  wr_data;
   logic                  row_live;

   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // A response word is produced by the modify stage or by a request that skips the RAM.
   assign rsp_done  = (state_ff == ST_READ) || (accept && !rd_en);

   // Lowest row whose full flag is clear.
   assign full_p1  = full_ff + 1'b1;
   assign free_oh  = ~full_ff & full_p1;
   assign any_free = ~(&full_ff);

   always_comb begin
      free_word = '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
         if (free_oh[i]) begin
            free_word = free_word | AW'(i);
         end
      end
   end

   // Row of a release ID by reciprocal multiply; exact for all 10-bit IDs.
   assign rel_prod     = 34'(req_word.release_id) * 34'(RECIP);
   assign rel_word     = rel_prod[RECIP_SHIFT +: ID_W];
   assign rel_in_range = 32'(rel_word) < 32'(NUM_WORDS);

   always_comb begin
      if (req_word.req_type == REQ_ALLOCATE) begin
         rd_en   = accept && any_free;
         rd_addr = free_word;
      end else begin
         rd_en   = accept && rel_in_range;
         rd_addr = AW'(32'(rel_word));
      end
   end

   // Modify stage. Rows never written yet read as all free.
   assign row_live = HW'(word_ff) < hwm_ff;
   assign cur_word = row_live ? rd_data : '0;
   assign cur_p1   = cur_word + 1'b1;
   assign zero_oh  = ~cur_word & cur_p1;
   assign set_word = cur_word | zero_oh;

   always_comb begin
      zero_bit = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (zero_oh[i]) begin
            zero_bit = zero_bit | BW'(i);
         end
      end
   end

   assign row_base  = 32'(word_ff) * 32'(WORD_BITS);
   assign grant_sum = row_base + 32'(zero_bit);
   assign rel_off   = id_ff - row_base[ID_W-1:0];
   assign rel_bit   = rel_off[BW-1:0];
   assign clr_word  = cur_word & ~(WORD_BITS'(1) << rel_bit);

   assign wr_en   = (state_ff == ST_READ);
   assign wr_data = (op_ff == REQ_ALLOCATE) ? set_word : clr_word;

   bia_map_ram #(
      .DEPTH (NUM_WORDS),
      .WIDTH (WORD_BITS),
      .AW    (AW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         full_ff      <= '0;
         hwm_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  op_ff   <= req_word.req_type;
                  id_ff   <= req_word.release_id;
                  word_ff <= rd_addr;
                  if (rd_en) begin
                     state_ff <= ST_READ;
                  end else begin
                     rsp_word_ff.granted_id <= '0;
                     rsp_word_ff.status     <= (req_word.req_type == REQ_ALLOCATE) ?
                                               STATUS_NO_FREE : STATUS_RELEASED;
                  end
               end
            end
            ST_READ: begin
               state_ff <= ST_IDLE;
               if (op_ff == REQ_ALLOCATE) begin
                  full_ff[word_ff]       <= &set_word;
                  rsp_word_ff.granted_id <= grant_sum[ID_W-1:0];
                  rsp_word_ff.status     <= STATUS_ALLOCATED;
               end else begin
                  full_ff[word_ff]       <= 1'b0;
                  rsp_word_ff.granted_id <= '0;
                  rsp_word_ff.status     <= STATUS_RELEASED;
               end
               if (HW'(word_ff) == hwm_ff) begin
                  hwm_ff <= hwm_ff + 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // The fill count never passes the number of rows.
   a_hwm_bound: assert property (@(posedge clock) disable iff (reset)
      32'(hwm_ff) <= 32'(NUM_WORDS))
      else $error("bitmap fill count exceeds the number of rows");

   // The modify stage always returns to idle in the next cycle and leaves a response behind.
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("modify stage did not complete in one cycle");

   // Only a successful allocate carries a nonzero ID.
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_word_ff.status != STATUS_ALLOCATED)) |->
      (rsp_word_ff.granted_id == '0))
      else $error("nonzero ID on a response that is not an allocation");

   // A response is never overwritten while the receiver stalls it.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_word_ff))
      else $error("stalled response changed");

endmodule
